// File: src/etca_pkg.sv
// Shared constants, codes and controller/datapath link types for the channel allocator.
`default_nettype none

package etca_pkg;

  // Table size and time width
  localparam int CHANNELS  = 4096;
  localparam int IDX_BITS  = $clog2(CHANNELS);
  localparam int TIME_BITS = 40;

  // Fixed field widths of the request and result words
  localparam int FUNC_W  = 2;
  localparam int NOW_W   = 40;
  localparam int COOL_W  = 24;
  localparam int INDEX_W = 12;

  // Hold and bound widths; compare and sum widths cover both the table time and the constants
  localparam int HOLD_BITS  = 36;
  localparam int BOUND_BITS = 37;
  localparam int CMP_BITS   = (TIME_BITS > BOUND_BITS) ? TIME_BITS : BOUND_BITS;
  localparam int SUM_BITS   = ((TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS) + 1;

  // 99999999 s scan bound and 366 day permanent hold, in ms
  localparam logic [CMP_BITS-1:0]  SCAN_BOUND_MS     = CMP_BITS'(64'd99999999000);
  localparam logic [HOLD_BITS-1:0] PERMANENT_HOLD_MS = HOLD_BITS'(64'd31622400000);
  localparam logic [TIME_BITS-1:0] TIME_MAX          = '1;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TIMED = 2'd0,
    FUNC_PERM  = 2'd1,
    FUNC_FREE  = 2'd2
  } func_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic take;
    logic scan;
    logic write;
    logic load;
  } etca_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic in_alloc;
    logic scan_done;
    logic out_free;
  } etca_sts_t;

endpackage

`default_nettype wire

// File: src/etca_in_if.sv
// Request channel interface: valid/ready handshake with the request word.
`default_nettype none

interface etca_in_if
  import etca_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [NOW_W-1:0]   now_ms;
  logic [COOL_W-1:0]  cooldown_ms;
  logic [INDEX_W-1:0] free_index;

  modport source (output valid, output func, output now_ms, output cooldown_ms,
                  output free_index, input ready);
  modport sink (input valid, input func, input now_ms, input cooldown_ms,
                input free_index, output ready);
endinterface

`default_nettype wire

// File: src/etca_out_if.sv
// Result channel interface: valid/ready handshake with the granted channel word.
`default_nettype none

interface etca_out_if
  import etca_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] channel_index;

  modport source (output valid, output channel_index, input ready);
  modport sink (input valid, input channel_index, output ready);
endinterface

`default_nettype wire

// File: src/etca_ctrl.sv
// Sequencing state machine: clear sweep, request intake, table scan, update, result.
`default_nettype none

module etca_ctrl
  import etca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  etca_sts_t sts,
  output etca_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_WRITE  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the sequence
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = sts.in_alloc ? ST_SCAN : ST_WRITE;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Decode commands from the state
  always_comb begin
    cmd.clear = (state == ST_CLEAR);
    cmd.take  = (state == ST_IDLE);
    cmd.scan  = (state == ST_SCAN);
    cmd.write = (state == ST_WRITE);
    cmd.load  = (state == ST_RESULT);
  end

endmodule

`default_nettype wire

// File: src/etca_dp.sv
// Datapath: expiry table memory, scan compare and best tracking, update adder, result register.
`default_nettype none

module etca_dp
  import etca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  etca_in_if.sink   req,
  etca_out_if.source rsp,
  input  etca_cmd_t cmd,
  output etca_sts_t sts
);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CHANNELS - 1);

  logic [TIME_BITS-1:0] mem [CHANNELS];

  logic [FUNC_W-1:0]    req_func;
  logic [TIME_BITS-1:0] req_now;
  logic [COOL_W-1:0]    req_cool;
  logic [INDEX_W-1:0]   req_free;

  logic [IDX_BITS-1:0]  cnt;
  logic [TIME_BITS-1:0] rd_data;
  logic [IDX_BITS-1:0]  rd_idx;
  logic                 rd_vld;
  logic                 done;
  logic [IDX_BITS-1:0]  best;
  logic [CMP_BITS-1:0]  best_time;
  logic                 res_valid;
  logic [INDEX_W-1:0]   res_index;

  logic                 accept;
  logic                 eval;
  logic                 lt_now;
  logic                 lt_best;
  logic                 is_alloc;
  logic                 free_ok;
  logic [HOLD_BITS-1:0] hold;
  logic [SUM_BITS-1:0]  sum;
  logic [TIME_BITS-1:0] alloc_time;
  logic                 we;
  logic [IDX_BITS-1:0]  wa;
  logic [TIME_BITS-1:0] wd;
  logic                 out_free;
  logic [INDEX_W-1:0]   res_val;

  assign accept = req.valid && req.ready;
  assign req.ready = cmd.take;

  // Scan compare on the entry read last cycle
  assign eval    = cmd.scan && rd_vld && !done;
  assign lt_now  = rd_data < req_now;
  assign lt_best = CMP_BITS'(rd_data) < best_time;

  assign is_alloc = (req_func == FUNC_TIMED) || (req_func == FUNC_PERM);
  assign free_ok  = (req_func == FUNC_FREE) && (32'(req_free) < 32'(CHANNELS));

  // New free time, saturated at the field maximum
  assign hold       = (req_func == FUNC_TIMED) ? HOLD_BITS'(req_cool) : PERMANENT_HOLD_MS;
  assign sum        = SUM_BITS'(req_now) + SUM_BITS'(hold);
  assign alloc_time = (sum > SUM_BITS'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];

  // Select the table write
  always_comb begin
    we = 1'b0;
    wa = cnt;
    wd = '0;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (cmd.write) begin
      we = is_alloc || free_ok;
      wa = is_alloc ? best : IDX_BITS'(req_free);
      wd = is_alloc ? alloc_time : req_now;
    end
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[cnt];
    rd_idx  <= cnt;
  end

  // Latch the request word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func <= req.func;
      req_now  <= TIME_BITS'(req.now_ms);
      req_cool <= req.cooldown_ms;
      req_free <= req.free_index;
    end
  end

  // Address counter for the clear sweep and the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (cmd.clear || (cmd.scan && !done)) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Track read pipeline and scan end
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else if (accept) begin
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      rd_vld <= cmd.scan && !done;
      if (eval && (lt_now || (rd_idx == LAST_IDX))) done <= 1'b1;
    end
  end

  // Hold the first expired entry, else the earliest one below the bound
  always_ff @(posedge clk) begin
    if (accept) begin
      best      <= '0;
      best_time <= SCAN_BOUND_MS;
    end else if (eval) begin
      if (lt_now) begin
        best <= rd_idx;
      end else if (lt_best) begin
        best      <= rd_idx;
        best_time <= CMP_BITS'(rd_data);
      end
    end
  end

  // Result word
  always_comb begin
    case (req_func)
      FUNC_TIMED, FUNC_PERM: res_val = INDEX_W'(best);
      FUNC_FREE:             res_val = req_free;
      default:               res_val = '0;
    endcase
  end

  assign out_free = !res_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load && out_free) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && out_free) res_index <= res_val;
  end

  assign rsp.valid         = res_valid;
  assign rsp.channel_index = res_index;

  // Status to the controller
  always_comb begin
    sts.clr_last  = (cnt == LAST_IDX);
    sts.in_alloc  = (req.func == FUNC_TIMED) || (req.func == FUNC_PERM);
    sts.scan_done = done;
    sts.out_free  = out_free;
  end

endmodule

`default_nettype wire

// File: src/expiry_time_channel_allocator_unit.sv
// Top level of the expiry-time channel allocator.
//
// Channels: req carries one request word (func, now_ms, cooldown_ms, free_index);
// rsp returns one word with channel_index for every request. Both use valid/ready.
// A word is taken on req only while the block is idle; one request is worked at a time.
// Allocate (timed or permanent) reads the expiry table one entry per cycle through the
// single memory read port, stopping at the first expired entry or, when no entry has
// expired, after the last entry. Free and unused codes skip the scan.
// The next request can be taken in the cycle after the result is loaded.
// Reset: a clearing pass writes zero to every one of the CHANNELS (4096) table entries,
// one entry per cycle; req.ready stays low during that pass.
// Stall: the result sits in an output register; the block takes the next request while
// it waits, and holds that one's result until rsp.ready frees the register.
`default_nettype none

module expiry_time_channel_allocator_unit
  import etca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  etca_in_if.sink    req,
  etca_out_if.source rsp
);

  etca_cmd_t cmd;
  etca_sts_t sts;

  // Sequencer
  etca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table and compare datapath
  etca_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

`default_nettype wire

// File: src/etca_chk.sv
// Port-level checker for the channel allocator, bound to the top level.
`default_nettype none

module etca_chk
  import etca_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [INDEX_W-1:0] rsp_index
);

  // Reset starts the clearing pass with both channels quiet
  a_reset_quiet: assert property (@(posedge clk) rst |=> !req_ready && !rsp_valid)
    else $error("ready or result seen right after reset");

  // One request at a time: intake closes after a word is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in work");

  // A new result appears only while intake is closed
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result raised while idle");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_index))
    else $error("stalled result changed");

endmodule

bind expiry_time_channel_allocator_unit etca_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_index (rsp.channel_index)
);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking bench for the expiry-time channel allocator: directed, random and bound probes.
`default_nettype none

module tb_top;
  import etca_pkg::*;

  // Own copies of the timing constants used by the allocation rule
  localparam logic [TIME_BITS-1:0] YEAR_HOLD_MS = 40'd31_622_400_000;
  localparam logic [TIME_BITS-1:0] BOUND_MS     = 40'd99_999_999_000;
  localparam logic [NOW_W-1:0]     NOW_MAX      = '1;
  localparam logic [NOW_W-1:0]     FILL_MS      = 40'd100_000_000_000;
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
  localparam int                   RAND_WORDS   = 107;
  localparam int                   MAX_REPORTS  = 10;

  // Table model: predicts the granted channel for each request word
  class grant_scoreboard;
    logic [TIME_BITS-1:0] busy_until [CHANNELS];
    logic [INDEX_W-1:0]   grant_q [$];
    int mismatches = 0;
    int checked = 0;
    int n_timed = 0;
    int n_perm = 0;
    int n_free = 0;
    int n_unused = 0;

    function new();
      foreach (busy_until[i]) busy_until[i] = '0;
    endfunction

    function logic [INDEX_W-1:0] note_request(logic [FUNC_W-1:0] f, logic [NOW_W-1:0] now,
                                              logic [COOL_W-1:0] cool,
                                              logic [INDEX_W-1:0] idx);
      logic [TIME_BITS-1:0] t_now;
      logic [TIME_BITS-1:0] hold;
      logic [TIME_BITS-1:0] best_t;
      logic [TIME_BITS:0]   sum;
      int                   pick;
      int                   best;
      logic [INDEX_W-1:0]   ch;
      t_now = TIME_BITS'(now);
      case (f)
        FUNC_TIMED, FUNC_PERM: begin
          if (f == FUNC_TIMED) begin
            hold = TIME_BITS'(cool);
            n_timed++;
          end else begin
            hold = YEAR_HOLD_MS;
            n_perm++;
          end
          // take the first expired channel, else the earliest one under the bound
          pick = -1;
          best = 0;
          best_t = BOUND_MS;
          for (int i = 0; i < CHANNELS; i++) begin
            if (busy_until[i] < t_now) begin
              pick = i;
              break;
            end
            if (busy_until[i] < best_t) begin
              best = i;
              best_t = busy_until[i];
            end
          end
          if (pick < 0) pick = best;
          // saturate the new free time at the field maximum
          sum = {1'b0, t_now} + {1'b0, hold};
          busy_until[pick] = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
          ch = pick[INDEX_W-1:0];
        end
        FUNC_FREE: begin
          if (idx < CHANNELS) busy_until[idx] = t_now;
          ch = idx;
          n_free++;
        end
        default: begin
          ch = '0;
          n_unused++;
        end
      endcase
      grant_q.push_back(ch);
      return ch;
    endfunction

    function void flag(string what, logic [INDEX_W-1:0] exp_ch, logic [INDEX_W-1:0] got_ch);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("MISMATCH %s: channel_index expected %0d, got %0d", what, exp_ch, got_ch);
    endfunction

    function void check_result(logic [INDEX_W-1:0] got_ch);
      logic [INDEX_W-1:0] exp_ch;
      if (grant_q.size() == 0) begin
        flag("word with no request waiting", 'x, got_ch);
      end else begin
        exp_ch = grant_q.pop_front();
        checked++;
        if (got_ch !== exp_ch) flag("wrong grant", exp_ch, got_ch);
      end
    endfunction

    function void check_leftover();
      while (grant_q.size() != 0) flag("result never arrived", grant_q.pop_front(), 'x);
    endfunction

    function int pending();
      return grant_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   idle_on = 1'b1;

  grant_scoreboard    sb = new();
  logic [INDEX_W-1:0] held_q [$];

  etca_in_if  req_if ();
  etca_out_if rsp_if ();

  expiry_time_channel_allocator_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Clock: period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Send one request word; note it at the accepting edge
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [NOW_W-1:0] now,
                           input logic [COOL_W-1:0] cool, input logic [INDEX_W-1:0] idx);
    logic [INDEX_W-1:0] ch;
    if (idle_on) begin
      while ($urandom_range(99) < 20) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= f;
    req_if.now_ms      <= now;
    req_if.cooldown_ms <= cool;
    req_if.free_index  <= idx;
    do @(posedge clk); while (!req_if.ready);
    ch = sb.note_request(f, now, cool, idx);
    if (f == FUNC_TIMED || f == FUNC_PERM) held_q.push_back(ch);
  endtask

  // Hold the sender until every expected word has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.channel_index);
    rsp_if.ready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
  end

  initial begin
    logic [NOW_W-1:0]   wall_ms;
    logic [NOW_W-1:0]   now;
    logic [COOL_W-1:0]  cool;
    logic [INDEX_W-1:0] idx;
    int                 r;
    int                 k;

    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.func        <= FUNC_TIMED;
    req_if.now_ms      <= '0;
    req_if.cooldown_ms <= '0;
    req_if.free_index  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, saturation, free of index zero, unused code
    send_word(FUNC_TIMED, 0, 0, 0);
    send_word(FUNC_TIMED, 0, 24'hFFFFFF, 12'hFFF);
    send_word(FUNC_PERM, 0, 24'h5A5A5A, 0);
    send_word(FUNC_TIMED, 5, 100, 0);
    send_word(FUNC_FREE, 3, 0, 0);
    send_word(FUNC_TIMED, 4, 10, 0);
    send_word(FUNC_FREE, NOW_MAX, 24'hFFFFFF, 12'hFFF);
    send_word(FUNC_FREE, 40'hAA_AAAA_AAAA, 24'hAAAAAA, 12'hAAA);
    send_word(FUNC_FREE, 40'h55_5555_5555, 24'h555555, 12'h555);
    send_word(FUNC_TIMED, NOW_MAX, 24'hFFFFFF, 0);
    send_word(FUNC_PERM, NOW_MAX - 5, 0, 0);
    send_word(FUNC_PERM, NOW_MAX - YEAR_HOLD_MS, 0, 0);
    send_word(FUNC_PERM, NOW_MAX - YEAR_HOLD_MS - 1, 0, 0);
    send_word(FUNC_TIMED, NOW_MAX - 40'hFFFFFF, 24'hFFFFFF, 0);
    send_word(FUNC_UNUSED, NOW_MAX, 24'hFFFFFF, 12'hFFF);
    send_word(FUNC_UNUSED, 40'h12_3456_789A, 24'h00FF00, 12'h0F0);
    send_word(FUNC_TIMED, NOW_MAX, 0, 0);
    send_word(FUNC_FREE, 0, 0, 12'hFFF);
    send_word(FUNC_TIMED, 1, 24'h555555, 0);
    send_word(FUNC_TIMED, 1, 24'hAAAAAA, 0);
    drain();
    held_q.delete();

    // Random: a running clock with allocate/free traffic, plus some noise
    wall_ms = 1000;
    for (int n = 0; n < RAND_WORDS; n++) begin
      idle_on = !(n >= 40 && n < 80);
      if ($urandom_range(5) != 0) wall_ms += NOW_W'($urandom_range(0, 3000));
      if ($urandom_range(15) == 0) wall_ms += NOW_W'($urandom_range(20000, 10_000_000));
      now  = wall_ms;
      cool = ($urandom_range(7) == 0) ? COOL_W'($urandom) : COOL_W'($urandom_range(0, 20000));
      idx  = INDEX_W'($urandom);
      r    = $urandom_range(99);
      if (r < 45) begin
        send_word(FUNC_TIMED, now, cool, idx);
      end else if (r < 58) begin
        send_word(FUNC_PERM, now, cool, idx);
      end else if (r < 88) begin
        // release a channel that was granted, mostly
        if (held_q.size() != 0 && $urandom_range(9) < 7) begin
          k   = $urandom_range(held_q.size() - 1);
          idx = held_q[k];
          held_q.delete(k);
        end
        send_word(FUNC_FREE, now, cool, idx);
      end else if (r < 93) begin
        send_word(FUNC_UNUSED, NOW_W'({$urandom, $urandom}), cool, idx);
      end else begin
        send_word(FUNC_TIMED, NOW_W'({$urandom, $urandom}), COOL_W'($urandom), idx);
      end
      if (n == 60 || $urandom_range(29) == 0) drain();
    end
    idle_on = 1'b1;
    drain();

    // Probe entries near the scan bound and ties
    send_word(FUNC_TIMED, FILL_MS, 24'd500, 0);
    send_word(FUNC_FREE, BOUND_MS, 0, 12'd101);
    send_word(FUNC_TIMED, 1000, 24'd50, 0);
    send_word(FUNC_FREE, BOUND_MS - 1, 0, 12'd3000);
    send_word(FUNC_FREE, BOUND_MS - 1, 0, 12'd102);
    send_word(FUNC_TIMED, 1000, 24'd0, 0);
    send_word(FUNC_TIMED, 1000, 24'd20, 0);
    send_word(FUNC_PERM, 1000, 0, 0);
    send_word(FUNC_FREE, 40'd7_000, 0, 12'd4000);
    send_word(FUNC_FREE, 40'd7_000, 0, 12'd3999);
    send_word(FUNC_TIMED, 2000, 24'd100, 0);
    send_word(FUNC_TIMED, FILL_MS + 1, 24'hFFFFFF, 0);
    send_word(FUNC_PERM, NOW_MAX, 0, 0);

    // Let the last words come back, then settle
    drain();
    repeat (20) @(posedge clk);
    sb.check_leftover();

    $display("Run covered %0d timed and %0d permanent allocates, %0d frees, %0d unused codes.",
             sb.n_timed, sb.n_perm, sb.n_free, sb.n_unused);
    $display("Bound and tie probes followed the random traffic; %0d words checked, %0d mismatches.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #16_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/etca_pkg.sv
src/etca_in_if.sv
src/etca_out_if.sv
src/etca_ctrl.sv
src/etca_dp.sv
src/expiry_time_channel_allocator_unit.sv
src/etca_chk.sv
test/tb_top.sv
